// ----- design/lpfb_pkg.sv -----
// ----------------------------------------------------------------------------
// lpfb_pkg
// shared constants, widths and types of the length-prefixed frame buffer
// ----------------------------------------------------------------------------
package lpfb_pkg;

    // default depth of the frame store
    localparam int STORE_DEPTH_DEF = 16;

    // field widths
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;

    // header byte fields
    localparam logic [BYTE_W-1:0] SIZE_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] REQ_MASK  = 8'hF0;

    // input function codes
    typedef enum logic
    {
        FUNC_RX_BYTE  = 1'b0,
        FUNC_READ_REQ = 1'b1
    } func_t;

    // result status codes
    typedef enum logic
    {
        STATUS_OK     = 1'b0,
        STATUS_NOT_OK = 1'b1
    } status_t;

endpackage

// ----- design/lpfb_in_if.sv -----
// ----------------------------------------------------------------------------
// lpfb_in_if
// input channel: received bytes and read requests, valid/ready handshake
// ----------------------------------------------------------------------------
interface lpfb_in_if;

    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [lpfb_pkg::BYTE_W-1:0]  rx_byte;
    logic [lpfb_pkg::NIB_W-1:0]   read_length;
    logic [lpfb_pkg::BYTE_W-1:0]  requester_mask;

    modport source
    (
        output valid,
        input  ready,
        output func,
        output rx_byte,
        output read_length,
        output requester_mask
    );

    modport sink
    (
        input  valid,
        output ready,
        input  func,
        input  rx_byte,
        input  read_length,
        input  requester_mask
    );

endinterface

// ----- design/lpfb_out_if.sv -----
// ----------------------------------------------------------------------------
// lpfb_out_if
// result channel: read-out frame bytes, valid/ready handshake
// ----------------------------------------------------------------------------
interface lpfb_out_if;

    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [lpfb_pkg::BYTE_W-1:0]  data_byte;
    logic                         last;

    modport source
    (
        output valid,
        input  ready,
        output status,
        output data_byte,
        output last
    );

    modport sink
    (
        input  valid,
        output ready,
        input  status,
        input  data_byte,
        input  last
    );

endinterface

// ----- design/length_prefixed_frame_buffer_core.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_buffer_core
// receive-side frame store for a length-prefixed serial protocol
// ----------------------------------------------------------------------------
// usage
//   req carries one beat per received serial byte (func 0) or per read
//   request (func 1). rsp carries the result beats of read requests only.
//   a received byte is written at the running fill index; the
//   byte at index 0 is the header (low nibble frame size, high nibble
//   requester bits). a read request is granted when all requester_mask bits
//   sit in the header high nibble and read_length equals the header size.
//   a granted read of n > 0 bytes streams bytes 0..n-1, last on the final
//   beat, and clears them; a failed or zero-length read gives one beat.
// sequencing
//   received byte: next beat taken in the following cycle
//   failed or zero-length read: result beat in the output register in the
//   cycle after acceptance
//   granted read: each byte runs ram read issue, data load and handoff in
//   turn, and the next byte is not read until rsp takes the current beat;
//   the frame store ram has a single read port walked by one byte counter
// reset / stall
//   reset empties the store through per-entry valid bits (unset entries read
//   as zero); fill index, frame size and header are cleared; req is not ready
//   during a read; a stalled rsp holds its beat and the read waits with it
// ----------------------------------------------------------------------------
module length_prefixed_frame_buffer_core #(
    parameter int STORE_DEPTH = lpfb_pkg::STORE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lpfb_in_if.sink   req,
    lpfb_out_if.source rsp
);

    localparam int AW = $clog2(STORE_DEPTH);

    // read sequencer states
    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,   // taking req beats
        S_RD   = 4'b0010,   // ram read issued at byte counter
        S_LD   = 4'b0100,   // ram data back, load output register
        S_OUT  = 4'b1000    // result beat waiting on rsp
    } state_t;

    state_t                        state_reg,     state_next;
    logic [lpfb_pkg::NIB_W-1:0]    fill_idx_reg,  fill_idx_next;
    logic [lpfb_pkg::NIB_W-1:0]    frm_size_reg,  frm_size_next;
    logic [lpfb_pkg::BYTE_W-1:0]   hdr_reg,       hdr_next;     // copy of store entry 0
    logic [STORE_DEPTH-1:0]        vld_reg,       vld_next;     // entry holds a written byte
    logic [lpfb_pkg::NIB_W-1:0]    cnt_reg,       cnt_next;     // byte being read out
    logic [lpfb_pkg::NIB_W-1:0]    len_reg,       len_next;
    logic                          rd_vld_reg,    rd_vld_next;  // valid bit of entry in flight
    logic                          out_valid_reg, out_valid_next;
    logic                          out_status_reg, out_status_next;
    logic [lpfb_pkg::BYTE_W-1:0]   out_data_reg,  out_data_next;
    logic                          out_last_reg,  out_last_next;

    logic                          in_fire;
    logic                          out_fire;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic [lpfb_pkg::BYTE_W-1:0]   rd_data;

    // frame reception
    logic [lpfb_pkg::NIB_W-1:0]    rx_size;
    logic [lpfb_pkg::NIB_W:0]      idx_inc;

    // read grant check against the header copy
    logic                          mask_ok;
    logic                          len_ok;
    logic                          grant;

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_fire  = rsp.valid && rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.data_byte = out_data_reg;
    assign rsp.last      = out_last_reg;

    // header byte takes its size at index 0, frame ends once the index reaches it
    assign rx_size = (fill_idx_reg == '0)
                   ? lpfb_pkg::NIB_W'(req.rx_byte & lpfb_pkg::SIZE_MASK)
                   : frm_size_reg;
    assign idx_inc = {1'b0, fill_idx_reg} + (lpfb_pkg::NIB_W+1)'(1);

    // low nibble requester bits can never match
    assign mask_ok = ((req.requester_mask & (hdr_reg & lpfb_pkg::REQ_MASK))
                      == req.requester_mask);
    assign len_ok  = (req.read_length == lpfb_pkg::NIB_W'(hdr_reg & lpfb_pkg::SIZE_MASK));
    assign grant   = mask_ok && len_ok;

    assign wr_en   = in_fire && (req.func == lpfb_pkg::FUNC_RX_BYTE);
    assign wr_addr = AW'(fill_idx_reg);
    assign rd_addr = AW'(cnt_reg);

    lpfb_ram #(
        .WIDTH (lpfb_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (req.rx_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_idx_next   = fill_idx_reg;
        frm_size_next   = frm_size_reg;
        hdr_next        = hdr_reg;
        vld_next        = vld_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        rd_vld_next     = rd_vld_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req.func == lpfb_pkg::FUNC_RX_BYTE)
                    begin
                        // store the byte, track the header copy
                        vld_next[wr_addr] = 1'b1;
                        if (fill_idx_reg == '0)
                        begin
                            hdr_next = req.rx_byte;
                        end
                        if (idx_inc >= {1'b0, rx_size})
                        begin
                            fill_idx_next = '0;
                            frm_size_next = '0;
                        end
                        else
                        begin
                            fill_idx_next = idx_inc[lpfb_pkg::NIB_W-1:0];
                            frm_size_next = rx_size;
                        end
                    end
                    else if (grant && (req.read_length != '0))
                    begin
                        // granted read, walk the frame one byte at a time
                        cnt_next   = '0;
                        len_next   = req.read_length;
                        state_next = S_RD;
                    end
                    else
                    begin
                        // refused or empty read, single closing beat
                        out_valid_next  = 1'b1;
                        out_status_next = grant ? lpfb_pkg::STATUS_OK
                                                : lpfb_pkg::STATUS_NOT_OK;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        state_next      = S_OUT;
                    end
                end
            end

            S_RD:
            begin
                rd_vld_next = vld_reg[rd_addr];
                state_next  = S_LD;
            end

            S_LD:
            begin
                out_valid_next  = 1'b1;
                out_status_next = lpfb_pkg::STATUS_OK;
                out_data_next   = rd_vld_reg ? rd_data : '0;
                out_last_next   = (cnt_reg == (len_reg - lpfb_pkg::NIB_W'(1)));
                // read-out clears the entry
                vld_next[rd_addr] = 1'b0;
                if (cnt_reg == '0)
                begin
                    hdr_next = '0;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + lpfb_pkg::NIB_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_idx_reg  <= '0;
            frm_size_reg  <= '0;
            hdr_reg       <= '0;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_idx_reg  <= fill_idx_next;
            frm_size_reg  <= frm_size_next;
            hdr_reg       <= hdr_next;
            vld_reg       <= vld_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rd_vld_reg     <= rd_vld_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ----- design/lpfb_ram.sv -----
// ----------------------------------------------------------------------------
// lpfb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for length_prefixed_frame_buffer_core: a directed part
// covering empty store, tiny and full frames, requester mask and length rules
// and reads during reception, then random frame traffic under three
// idle/stall mixes; every result beat is compared with a predicted beat
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = lpfb_pkg::STORE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 420;

    // one predicted result beat
    typedef struct {
        lpfb_pkg::status_t                  status;
        logic [lpfb_pkg::BYTE_W-1:0]        data_byte;
        logic                               last;
    } frame_beat_t;

    logic clk;
    logic rst_n;

    lpfb_in_if  req_if();
    lpfb_out_if rsp_if();

    length_prefixed_frame_buffer_core #(
        .STORE_DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // bench copy of the block state
    logic [lpfb_pkg::BYTE_W-1:0] shadow_store [DEPTH];
    logic [lpfb_pkg::NIB_W-1:0]  shadow_fill;
    logic [lpfb_pkg::NIB_W-1:0]  shadow_size;

    // read-out beats still owed by the block, oldest first
    frame_beat_t owed_beats[$];

    int error_count = 0;
    int item_count  = 0;
    int cycle_count = 0;

    // idle and stall chances in percent, changed per traffic phase
    int send_idle_pct  = 0;
    int drain_stall_pct = 0;

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic clear_shadow();
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        shadow_fill = '0;
        shadow_size = '0;
    endtask

    // work out what one accepted beat does to the store and which result
    // beats it owes
    task automatic predict_frame_beat(input lpfb_pkg::func_t f,
                                      input logic [lpfb_pkg::BYTE_W-1:0] rx,
                                      input logic [lpfb_pkg::NIB_W-1:0] len,
                                      input logic [lpfb_pkg::BYTE_W-1:0] mask);
        int                          next_idx;
        logic [lpfb_pkg::BYTE_W-1:0] hdr;
        logic                        granted;
        frame_beat_t                 b;
        if (f == lpfb_pkg::FUNC_RX_BYTE)
        begin
            shadow_store[shadow_fill] = rx;
            // header sets the frame size
            if (shadow_fill == 0)
                shadow_size = rx[lpfb_pkg::NIB_W-1:0];
            next_idx = int'(shadow_fill) + 1;
            // frame end: sizes 0 and 1 end right after the header
            if (next_idx >= int'(shadow_size))
            begin
                shadow_fill = '0;
                shadow_size = '0;
            end
            else
                shadow_fill = next_idx[lpfb_pkg::NIB_W-1:0];
        end
        else
        begin
            hdr     = shadow_store[0];
            // requester bits in the low nibble can never be matched
            granted = ((mask & (hdr & lpfb_pkg::REQ_MASK)) == mask)
                      && (len == hdr[lpfb_pkg::NIB_W-1:0]);
            if (!granted || len == 0)
            begin
                if (granted)
                    b.status = lpfb_pkg::STATUS_OK;
                else
                    b.status = lpfb_pkg::STATUS_NOT_OK;
                b.data_byte = '0;
                b.last      = 1'b1;
                owed_beats.push_back(b);
            end
            else
            begin
                // granted read streams bytes 0..len-1 and clears them
                for (int i = 0; i < int'(len); i++)
                begin
                    b.status    = lpfb_pkg::STATUS_OK;
                    b.data_byte = shadow_store[i];
                    b.last      = (i == int'(len) - 1);
                    owed_beats.push_back(b);
                    shadow_store[i] = '0;
                end
            end
        end
    endtask

    // drive one request beat at the falling edge, hold it until the block
    // takes it at a rising edge, then update the prediction
    task automatic send_frame_beat(input lpfb_pkg::func_t f,
                                   input logic [lpfb_pkg::BYTE_W-1:0] rx,
                                   input logic [lpfb_pkg::NIB_W-1:0] len,
                                   input logic [lpfb_pkg::BYTE_W-1:0] mask);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge clk);
        end
        req_if.valid          = 1'b1;
        req_if.func           = f;
        req_if.rx_byte        = rx;
        req_if.read_length    = len;
        req_if.requester_mask = mask;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predict_frame_beat(f, rx, len, mask);
        item_count++;
    endtask

    // unused fields carry random values so every bit toggles
    task automatic send_rx(input logic [lpfb_pkg::BYTE_W-1:0] rx);
        send_frame_beat(lpfb_pkg::FUNC_RX_BYTE, rx, lpfb_pkg::NIB_W'($urandom),
                        lpfb_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_read(input logic [lpfb_pkg::NIB_W-1:0] len,
                             input logic [lpfb_pkg::BYTE_W-1:0] mask);
        send_frame_beat(lpfb_pkg::FUNC_READ_REQ, lpfb_pkg::BYTE_W'($urandom), len, mask);
    endtask

    // release the request channel and wait for every owed beat, then let the
    // block settle for its longest read
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (owed_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // receiver side: random stall decided at each falling edge
    always @(negedge clk)
        rsp_if.ready = ($urandom_range(99) >= drain_stall_pct);

    // result checker: compare each taken beat with the oldest owed beat
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (owed_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat data 0x%02h status %0b last %0b",
                                          rsp_if.data_byte, rsp_if.status, rsp_if.last));
            else
            begin
                want = owed_beats.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              rsp_if.status, want.status));
                if (rsp_if.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data_byte 0x%02h, expected 0x%02h",
                                              rsp_if.data_byte, want.data_byte));
                if (rsp_if.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              rsp_if.last, want.last));
            end
        end
    end

    // store as left by reset: header 0 means size 0 and no requester bits
    task automatic test_empty_store();
        send_read(4'd0, 8'h00);
        // low-nibble requester bit can never match
        send_read(4'd0, 8'h01);
        wait_drained();
    endtask

    // frames of size 0 and 1 end right after the header
    task automatic test_tiny_frames();
        send_rx(8'h00);
        send_read(4'd0, 8'h00);
        send_rx(8'hA1);
        // granted single-byte read clears the header
        send_read(4'd1, 8'hA0);
        wait_drained();
    endtask

    // largest frame with all requester bits, byte extremes inside
    task automatic test_full_frame();
        send_rx(8'hFF);
        send_rx(8'h00);
        send_rx(8'hFF);
        repeat (12) send_rx(lpfb_pkg::BYTE_W'($urandom));
        send_read(4'd15, 8'hFF);
        send_read(4'd15, 8'hF0);
        wait_drained();
    endtask

    // mask and length rules, and a read while the frame is still arriving
    task automatic test_mask_rules();
        send_rx(8'h53);
        send_rx(8'h7E);
        // bit 5 not in header high nibble
        send_read(4'd3, 8'h20);
        // right mask, wrong length
        send_read(4'd2, 8'h40);
        // granted mid-frame, fill index untouched
        send_read(4'd3, 8'h50);
        send_rx(8'h22);
        wait_drained();
    endtask

    // mostly well-formed frames followed by a read, some broken frames and
    // plain noise in between
    task automatic test_random_traffic(input int stop_at);
        int                          kind;
        logic [lpfb_pkg::NIB_W-1:0]  hi;
        logic [lpfb_pkg::NIB_W-1:0]  sz;
        logic [lpfb_pkg::NIB_W-1:0]  len;
        logic [lpfb_pkg::BYTE_W-1:0] mask;
        int                          cut;
        while (item_count < stop_at)
        begin
            kind = $urandom_range(99);
            hi   = lpfb_pkg::NIB_W'($urandom);
            // small frames most of the time
            sz   = ($urandom_range(9) < 7) ? lpfb_pkg::NIB_W'($urandom_range(5)) :
                                             lpfb_pkg::NIB_W'($urandom_range(15, 6));
            mask = ($urandom_range(99) < 80) ? {hi & lpfb_pkg::NIB_W'($urandom), 4'h0} :
                                               lpfb_pkg::BYTE_W'($urandom);
            len  = ($urandom_range(99) < 85) ? sz : lpfb_pkg::NIB_W'($urandom);
            if (kind < 70)
            begin
                send_rx({hi, sz});
                for (int i = 1; i < int'(sz); i++)
                    send_rx(lpfb_pkg::BYTE_W'($urandom));
                send_read(len, mask);
            end
            else if (kind < 85)
            begin
                // frame cut short, read lands during reception
                cut = (sz > 1) ? $urandom_range(int'(sz) - 1, 1) : 1;
                send_rx({hi, sz});
                for (int i = 1; i < cut; i++)
                    send_rx(lpfb_pkg::BYTE_W'($urandom));
                send_read(len, mask);
            end
            else if (kind < 93)
                send_read(lpfb_pkg::NIB_W'($urandom), lpfb_pkg::BYTE_W'($urandom));
            else
                send_rx(lpfb_pkg::BYTE_W'($urandom));
        end
        wait_drained();
    endtask

    initial
    begin
        int phase_items;
        rst_n                 = 1'b0;
        req_if.valid          = 1'b0;
        req_if.func           = lpfb_pkg::FUNC_RX_BYTE;
        req_if.rx_byte        = '0;
        req_if.read_length    = '0;
        req_if.requester_mask = '0;
        clear_shadow();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part and first random phase with a slow sender and a busy receiver
        send_idle_pct   = 12;
        drain_stall_pct = 70;
        test_empty_store();
        test_tiny_frames();
        test_full_frame();
        test_mask_rules();

        phase_items = RANDOM_ITEMS / 3;
        test_random_traffic(item_count + phase_items);

        // swap: sender idles a lot, receiver rarely stalls
        send_idle_pct   = 70;
        drain_stall_pct = 12;
        test_random_traffic(item_count + phase_items);

        // full rate on both sides
        send_idle_pct   = 0;
        drain_stall_pct = 0;
        test_random_traffic(item_count + phase_items);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
